// File: hdl/psg_pkg.sv
// Package for the three-channel sound generator: shared types, constants and
// the logarithmic level table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psg_pkg;

	localparam int unsigned STEP_W = 24;
	localparam logic [STEP_W-1:0] STEP_RESET = 24'd332466;
	localparam logic [3:0] REG_SHAPE = 4'd13;
	localparam logic [3:0] REG_MIXER = 4'd7;
	localparam logic [3:0] REG_NOISE = 4'd6;
	localparam logic [3:0] REG_ENV_LO = 4'd11;
	localparam logic [3:0] REG_ENV_HI = 4'd12;
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic       tick;
		logic [3:0] addr;
		logic [7:0] data;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TONE,
		ST_NOISE,
		ST_ENV,
		ST_MIX,
		ST_OUT
	} eng_state_t;

	function automatic logic [13:0] level_rom(input logic [3:0] i);
		case (i)
			4'd0: level_rom = 14'd0;
			4'd1: level_rom = 14'd95;
			4'd2: level_rom = 14'd134;
			4'd3: level_rom = 14'd190;
			4'd4: level_rom = 14'd268;
			4'd5: level_rom = 14'd379;
			4'd6: level_rom = 14'd536;
			4'd7: level_rom = 14'd757;
			4'd8: level_rom = 14'd1069;
			4'd9: level_rom = 14'd1510;
			4'd10: level_rom = 14'd2133;
			4'd11: level_rom = 14'd3014;
			4'd12: level_rom = 14'd4257;
			4'd13: level_rom = 14'd6014;
			4'd14: level_rom = 14'd8495;
			default: level_rom = 14'd12000;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: hdl/psg_front.sv
// Front end: accepts requests, drops writes above register 15 and queues
// commands for the engine. Depends on psg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psg_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic          req_type,
	input  wire logic [7:0]    reg_addr,
	input  wire logic [7:0]    reg_data,
	output logic               cmd_valid,
	input  wire logic          cmd_take,
	output psg_pkg::cmd_t      cmd
);
	psg_pkg::cmd_t fifo_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic keep, take;

	assign full = cnt_q[2];
	assign keep = push && !full && (req_type == psg_pkg::REQ_TICK || reg_addr[7:4] == 4'd0);
	assign cmd_valid = cnt_q != 3'd0;
	assign take = cmd_take && cmd_valid;
	assign cmd = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (keep) begin
			fifo_q[wr_q] <= '{tick: req_type, addr: reg_addr[3:0], data: reg_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (keep) wr_q <= wr_q + 2'd1;
			if (take) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, keep} - {2'b0, take};
		end
	end

`ifndef SYNTHESIS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("queue count overflow");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		full && !take |=> full) else $error("full dropped without a take");
	a_take_dec: assert property (@(posedge clk) disable iff (!arst_n)
		take && !keep |=> cnt_q == $past(cnt_q) - 3'd1) else $error("count slip");
`endif
endmodule
`default_nettype wire

// File: hdl/psg_engine.sv
// Back end: register file, tone, noise and envelope generators and mixer.
// Divisions run bit-serially. Depends on psg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psg_engine #(
	parameter int NUM_CHANNELS = 3,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [psg_pkg::STEP_W-1:0] step_amt,
	input  wire logic                      cmd_valid,
	output logic                           cmd_take,
	input  wire psg_pkg::cmd_t             cmd,
	output logic                           res_valid,
	output logic [15:0]                    res_data,
	input  wire logic                      res_take
);
	localparam int CW = 21 + FRAC_BITS + 1;  // covers count + step for every counter
	localparam int QW = CW;
	localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int BW = $clog2(CW + 1);
	localparam int MW = 19;

	logic [7:0] regs_q [16];
	logic [CW-1:0] tone_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] tlev_q;
	logic [CW-1:0] ncnt_q, ecnt_q;
	logic [16:0] lfsr_q;
	logic nlev_q;
	logic [4:0] elev_q;
	logic att_q, alt_q, hold_q, holding_q;

	psg_pkg::eng_state_t st_q, st_d;
	logic [1:0] ph_q;           // 0 load, 1 divide, 2 apply
	logic [CHW-1:0] ch_q;
	logic [BW-1:0] bit_q;
	logic [CW-1:0] per_q, rem_q, num_q;
	logic [QW-1:0] quo_q;
	logic [6:0] steps_q;        // all ones marks a step count still to be loaded
	logic [MW-1:0] mix_q;
	logic out_full_q;
	logic [15:0] out_q;
	logic out_free;

	// Periods for the unit in hand, in counter units.
	logic [3:0] ra, rb;
	logic [CW-1:0] tper, nper, eper, cur_per, cur_cnt;
	always_comb begin
		ra = 4'(2 * ch_q);
		rb = 4'(2 * ch_q + 1);
		tper = CW'({regs_q[rb][3:0], regs_q[ra]});
		if (tper == '0) tper = CW'(1);
		tper = tper << FRAC_BITS;
		nper = CW'({regs_q[psg_pkg::REG_NOISE][4:0], 2'b00});
		if (nper == '0) nper = CW'(2);
		nper = nper << FRAC_BITS;
		eper = CW'({regs_q[psg_pkg::REG_ENV_HI], regs_q[psg_pkg::REG_ENV_LO]});
		if (eper == '0) eper = CW'(1);
		eper = (eper << 5) << FRAC_BITS;
		case (st_q)
			psg_pkg::ST_TONE: begin cur_per = tper; cur_cnt = tone_q[ch_q]; end
			psg_pkg::ST_NOISE: begin cur_per = nper; cur_cnt = ncnt_q; end
			default: begin cur_per = eper; cur_cnt = ecnt_q; end
		endcase
	end

	// Restoring divider step.
	logic [CW:0] trial;
	assign trial = {rem_q, num_q[CW-1]} - {1'b0, per_q};

	// One envelope step.
	logic [4:0] e_nlev;
	logic e_natt, e_nholding;
	always_comb begin
		logic [5:0] nx;
		nx = {1'b0, elev_q} + (att_q ? 6'd1 : 6'h3F);
		e_natt = att_q;
		e_nholding = holding_q;
		e_nlev = nx[4:0];
		if (holding_q) begin
			e_nlev = elev_q;
		end else if (nx[5] || nx[4]) begin
			if (hold_q) begin
				e_nlev = (nx[5] ? 5'd0 : 5'd15) ^ (alt_q ? 5'd15 : 5'd0);
				e_nholding = 1'b1;
			end else begin
				if (alt_q) e_natt = !att_q;
				e_nlev = (alt_q ? !att_q : att_q) ? 5'd0 : 5'd15;
			end
		end
	end

	// Mixer contribution of channel ch_q.
	logic [13:0] chan_lvl;
	always_comb begin
		logic ten, nen, on;
		logic [7:0] vm;
		logic [3:0] vol;
		ten = !regs_q[psg_pkg::REG_MIXER][3'(ch_q)];
		nen = (32'(ch_q) + 3 < 8) ? !regs_q[psg_pkg::REG_MIXER][3'(32'(ch_q) + 3)] : 1'b1;
		vm = regs_q[4'(8 + 32'(ch_q))];
		vol = vm[4] ? elev_q[3:0] : vm[3:0];
		if (ten && nen) on = tlev_q[ch_q] & nlev_q;
		else if (ten) on = tlev_q[ch_q];
		else if (nen) on = nlev_q;
		else on = 1'b1;
		chan_lvl = on ? psg_pkg::level_rom(vol) : 14'd0;
	end

	logic last_ch;
	assign last_ch = 32'(ch_q) == NUM_CHANNELS - 1;
	// The output register is free when empty or when its result leaves at this edge.
	assign out_free = !out_full_q || res_take;
	assign cmd_take = st_q == psg_pkg::ST_IDLE && cmd_valid;
	assign res_valid = out_full_q;
	assign res_data = out_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			psg_pkg::ST_IDLE: if (cmd_take && cmd.tick) st_d = psg_pkg::ST_TONE;
			psg_pkg::ST_TONE: if (ph_q == 2'd2 && last_ch) st_d = psg_pkg::ST_NOISE;
			psg_pkg::ST_NOISE: if (ph_q == 2'd2 && quo_q == '0) st_d = psg_pkg::ST_ENV;
			psg_pkg::ST_ENV: if (ph_q == 2'd2 && steps_q == '0) st_d = psg_pkg::ST_MIX;
			psg_pkg::ST_MIX: if (last_ch) st_d = psg_pkg::ST_OUT;
			psg_pkg::ST_OUT: if (out_free) st_d = psg_pkg::ST_IDLE;
			default: st_d = psg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= psg_pkg::ST_IDLE;
			for (int i = 0; i < 16; i++) regs_q[i] <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) tone_q[i] <= '0;
			tlev_q <= '0;
			ncnt_q <= '0;
			ecnt_q <= '0;
			lfsr_q <= 17'd1;
			nlev_q <= 1'b0;
			elev_q <= '0;
			{att_q, alt_q, hold_q, holding_q} <= '0;
			out_full_q <= 1'b0;
			out_q <= '0;
			ph_q <= '0;
			ch_q <= '0;
			bit_q <= '0;
			per_q <= '0;
			rem_q <= '0;
			num_q <= '0;
			quo_q <= '0;
			steps_q <= '0;
			mix_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == psg_pkg::ST_OUT && out_free) out_full_q <= 1'b1;
			else if (res_take) out_full_q <= 1'b0;
			case (st_q)
				psg_pkg::ST_IDLE: begin
					ph_q <= '0;
					ch_q <= '0;
					mix_q <= '0;
					if (cmd_take && !cmd.tick) begin
						regs_q[cmd.addr] <= cmd.data;
						if (cmd.addr == psg_pkg::REG_SHAPE) begin
							ecnt_q <= '0;
							holding_q <= 1'b0;
							if (!cmd.data[3]) begin
								att_q <= 1'b0; alt_q <= 1'b0; hold_q <= 1'b1;
								elev_q <= 5'd15;
							end else begin
								att_q <= cmd.data[2]; alt_q <= cmd.data[1];
								hold_q <= cmd.data[0];
								elev_q <= cmd.data[2] ? 5'd0 : 5'd15;
							end
						end
					end
				end
				psg_pkg::ST_TONE, psg_pkg::ST_NOISE, psg_pkg::ST_ENV: begin
					case (ph_q)
						2'd0: begin
							per_q <= cur_per;
							num_q <= cur_cnt + CW'(step_amt);
							rem_q <= '0;
							quo_q <= '0;
							bit_q <= BW'(CW);
							ph_q <= 2'd1;
						end
						2'd1: begin
							if (!trial[CW]) begin
								rem_q <= trial[CW-1:0];
								quo_q <= {quo_q[QW-2:0], 1'b1};
							end else begin
								rem_q <= {rem_q[CW-2:0], num_q[CW-1]};
								quo_q <= {quo_q[QW-2:0], 1'b0};
							end
							num_q <= {num_q[CW-2:0], 1'b0};
							bit_q <= bit_q - BW'(1);
							if (bit_q == BW'(1)) ph_q <= 2'd2;
							if (st_q == psg_pkg::ST_ENV) steps_q <= '1;
						end
						default: begin
							if (st_q == psg_pkg::ST_TONE) begin
								tone_q[ch_q] <= rem_q;
								if (quo_q >= QW'(2)) tlev_q[ch_q] <= 1'b1;
								else if (quo_q == QW'(1)) tlev_q[ch_q] <= !tlev_q[ch_q];
								ph_q <= 2'd0;
								if (!last_ch) ch_q <= ch_q + CHW'(1);
								else ch_q <= '0;
							end else if (st_q == psg_pkg::ST_NOISE) begin
								// Noise steps once per cycle until the quotient runs out.
								ncnt_q <= rem_q;
								if (quo_q != '0) begin
									lfsr_q <= {lfsr_q[0] ^ lfsr_q[3], lfsr_q[16:1]};
									nlev_q <= lfsr_q[1];
									quo_q <= quo_q - QW'(1);
								end else ph_q <= 2'd0;
							end else begin
								ecnt_q <= rem_q;
								if (steps_q == '1) begin
									steps_q <= (quo_q >= QW'(64)) ?
										{2'b01, quo_q[4:0]} : {1'b0, quo_q[5:0]};
								end else if (steps_q != '0) begin
									elev_q <= e_nlev;
									att_q <= e_natt;
									holding_q <= e_nholding;
									steps_q <= steps_q - 7'd1;
								end else ph_q <= 2'd0;
							end
						end
					endcase
				end
				psg_pkg::ST_MIX: begin
					mix_q <= mix_q + MW'(chan_lvl);
					ch_q <= last_ch ? '0 : ch_q + CHW'(1);
				end
				psg_pkg::ST_OUT: begin
					if (out_free)
						out_q <= (mix_q > MW'(16'hFFFF)) ? 16'hFFFF : mix_q[15:0];
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_full_q && !res_take |=> out_full_q && $stable(out_q))
		else $error("result lost while waiting");
	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == psg_pkg::ST_OUT && !out_free |=> st_q == psg_pkg::ST_OUT)
		else $error("result dropped over a waiting one");
	a_idle_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> st_q == psg_pkg::ST_IDLE) else $error("command taken while busy");
`endif
endmodule
`default_nettype wire

// File: hdl/psg_three_channel_sound_generator.sv
// Top level of the three-channel sound generator: front queue plus engine.
// Depends on psg_pkg, psg_front and psg_engine.
// A register write is applied in the engine's idle state. A sample tick
// runs a bit-serial divider of CW = FRAC_BITS + 22 bits for each tone
// channel, for noise and for the envelope, then the noise LFSR steps (at
// most 2^(23-FRAC_BITS) + 1) and the envelope steps (at most 63). A
// four-entry queue takes requests while the engine is busy; one result waits
// in an output register, and a tick finishing while it is still unread holds
// in its last cycle.
`timescale 1ns / 1ps
`default_nettype none
module psg_three_channel_sound_generator #(
	parameter int NUM_CHANNELS = 3,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        req_type,
	input  wire logic [7:0]  reg_addr,
	input  wire logic [7:0]  reg_data,
	output logic             empty,
	input  wire logic        pop,
	output logic [15:0]      mix_sample,
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_wdata
);
	logic [psg_pkg::STEP_W-1:0] step_q;
	logic cmd_valid, cmd_take, res_valid;
	psg_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= psg_pkg::STEP_RESET;
		else if (cfg_we) step_q <= cfg_wdata;
	end

	psg_front u_front (
		.clk, .arst_n, .push, .full, .req_type, .reg_addr, .reg_data,
		.cmd_valid, .cmd_take, .cmd
	);

	psg_engine #(.NUM_CHANNELS(NUM_CHANNELS), .FRAC_BITS(FRAC_BITS)) u_engine (
		.clk, .arst_n, .step_amt(step_q), .cmd_valid, .cmd_take, .cmd,
		.res_valid, .res_data(mix_sample), .res_take(pop)
	);

	assign empty = !res_valid;
endmodule
`default_nettype wire
